FILE: sv/dwq_pkg.sv
// Shared types, status codes and the control store of the work queue sequencer.
package dwq_pkg;

	localparam int ID_W   = 32;
	localparam int STAT_W = 3;
	localparam int STEP_W = 4;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ENQUEUED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_DEQUEUED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

	typedef logic [STEP_W-1:0] step_t;

	// program addresses
	localparam step_t STEP_WAIT     = 4'd0;
	localparam step_t STEP_DISPATCH = 4'd1;
	localparam step_t STEP_PUSH     = 4'd2;
	localparam step_t STEP_SCAN     = 4'd3;
	localparam step_t STEP_SCAN_END = 4'd4;
	localparam step_t STEP_ENQ      = 4'd5;
	localparam step_t STEP_FULL     = 4'd6;
	localparam step_t STEP_DUP      = 4'd7;
	localparam step_t STEP_POP      = 4'd8;
	localparam step_t STEP_POP_TAKE = 4'd9;
	localparam step_t STEP_EMPTY    = 4'd10;
	localparam step_t STEP_EMIT     = 4'd11;
	localparam step_t STEP_HOLD     = 4'd12;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_SCAN_INIT = 4'd1,
		ACT_SCAN_STEP = 4'd2,
		ACT_ENQ       = 4'd3,
		ACT_SET_FULL  = 4'd4,
		ACT_SET_DUP   = 4'd5,
		ACT_POP_RD    = 4'd6,
		ACT_DEQ       = 4'd7,
		ACT_SET_EMPTY = 4'd8,
		ACT_EMIT      = 4'd9
	} act_t;

	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_NO_ACCEPT = 3'd1,
		C_POP       = 3'd2,
		C_FULL      = 3'd3,
		C_SCAN_BUSY = 3'd4,
		C_HIT       = 3'd5,
		C_EMPTY     = 3'd6,
		C_OUT_FREE  = 3'd7
	} cond_t;

	// one control word: taken branch goes to target, else to the next step
	typedef struct packed {
		logic  in_rdy;
		act_t  act;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic hit;
		logic scan_busy;
	} dp_flags_t;

	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t w;
		w = '{in_rdy: 1'b0, act: ACT_NONE, cond: C_ALWAYS, target: STEP_WAIT};
		unique case (step)
			STEP_WAIT:     w = '{1'b1, ACT_NONE,      C_NO_ACCEPT, STEP_WAIT};
			STEP_DISPATCH: w = '{1'b0, ACT_NONE,      C_POP,       STEP_POP};
			STEP_PUSH:     w = '{1'b0, ACT_SCAN_INIT, C_FULL,      STEP_FULL};
			STEP_SCAN:     w = '{1'b0, ACT_SCAN_STEP, C_SCAN_BUSY, STEP_SCAN};
			STEP_SCAN_END: w = '{1'b0, ACT_NONE,      C_HIT,       STEP_DUP};
			STEP_ENQ:      w = '{1'b0, ACT_ENQ,       C_ALWAYS,    STEP_EMIT};
			STEP_FULL:     w = '{1'b0, ACT_SET_FULL,  C_ALWAYS,    STEP_EMIT};
			STEP_DUP:      w = '{1'b0, ACT_SET_DUP,   C_ALWAYS,    STEP_EMIT};
			STEP_POP:      w = '{1'b0, ACT_POP_RD,    C_EMPTY,     STEP_EMPTY};
			STEP_POP_TAKE: w = '{1'b0, ACT_DEQ,       C_ALWAYS,    STEP_EMIT};
			STEP_EMPTY:    w = '{1'b0, ACT_SET_EMPTY, C_ALWAYS,    STEP_EMIT};
			STEP_EMIT:     w = '{1'b0, ACT_EMIT,      C_OUT_FREE,  STEP_WAIT};
			STEP_HOLD:     w = '{1'b0, ACT_NONE,      C_ALWAYS,    STEP_EMIT};
			default:       w = '{1'b0, ACT_NONE,      C_ALWAYS,    STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/dwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dwq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/dwq_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
module dwq_seq import dwq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       out_busy,
	input  dp_flags_t  flags,
	output ctrl_word_t ctrl
);

	step_t upc_q;
	logic  taken;

	assign ctrl = ucode_rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:    taken = 1'b1;
			C_NO_ACCEPT: taken = !accept;
			C_POP:       taken = flags.is_pop;
			C_FULL:      taken = flags.full;
			C_SCAN_BUSY: taken = flags.scan_busy;
			C_HIT:       taken = flags.hit;
			C_EMPTY:     taken = flags.empty;
			C_OUT_FREE:  taken = !out_busy;
			default:     taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_WAIT;
		end else if (taken) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + step_t'(1);
		end
	end

endmodule

FILE: sv/dwq_datapath.sv
// Queue datapath: head and count registers, scan pointer, comparator and entry store.
module dwq_datapath import dwq_pkg::*; #(
	parameter int QUEUE_DEPTH = 256,
	localparam int IDX_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              operation,
	input  logic [ID_W-1:0]   relation_id,
	input  act_t              act,
	output dp_flags_t         flags,
	output logic [STAT_W-1:0] res_status,
	output logic [ID_W-1:0]   res_served,
	output logic [CNT_W-1:0]  res_pending
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_ptr_q;
	logic [CNT_W-1:0]  scan_left_q;
	logic              cmp_vld_q;
	logic              hit_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   served_q;

	logic              ram_we;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ID_W-1:0]   ram_rdata;
	logic [IDX_W:0]    tail_sum;
	logic [IDX_W-1:0]  tail_idx;
	logic              scan_issue;
	logic              match;

	// tail = (head + count) mod depth; the sum stays below twice the depth
	assign tail_sum = {1'b0, head_q} + {1'b0, count_q[IDX_W-1:0]};
	assign tail_idx = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X) : tail_sum[IDX_W-1:0];

	assign scan_issue = (act == ACT_SCAN_STEP) && (scan_left_q != '0);
	assign match      = cmp_vld_q && (ram_rdata == id_q);

	assign ram_we    = (act == ACT_ENQ);
	assign ram_re    = scan_issue || (act == ACT_POP_RD);
	assign ram_raddr = (act == ACT_POP_RD) ? head_q : scan_ptr_q;

	dwq_ram #(
		.WIDTH (ID_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_idx),
		.wdata (id_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			id_q <= relation_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			cmp_vld_q   <= 1'b0;
			hit_q       <= 1'b0;
			status_q    <= ST_EMPTY;
			served_q    <= '0;
		end else begin
			unique case (act)
				ACT_SCAN_INIT: begin
					scan_ptr_q  <= head_q;
					scan_left_q <= count_q;
					cmp_vld_q   <= 1'b0;
					hit_q       <= 1'b0;
				end
				ACT_SCAN_STEP: begin
					// compare the word read last cycle while the next read goes out
					hit_q     <= match;
					cmp_vld_q <= scan_issue;
					if (scan_issue) begin
						scan_ptr_q  <= (scan_ptr_q == LAST_IDX) ? '0 : scan_ptr_q + 1'b1;
						scan_left_q <= scan_left_q - 1'b1;
					end
				end
				ACT_ENQ: begin
					count_q  <= count_q + 1'b1;
					status_q <= ST_ENQUEUED;
					served_q <= '0;
				end
				ACT_SET_FULL: begin
					status_q <= ST_FULL;
					served_q <= '0;
				end
				ACT_SET_DUP: begin
					status_q <= ST_DUPLICATE;
					served_q <= '0;
				end
				ACT_DEQ: begin
					head_q   <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
					count_q  <= count_q - 1'b1;
					status_q <= ST_DEQUEUED;
					served_q <= ram_rdata;
				end
				ACT_SET_EMPTY: begin
					status_q <= ST_EMPTY;
					served_q <= '0;
				end
				ACT_NONE, ACT_POP_RD, ACT_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign flags.is_pop    = (op_q == OP_POP);
	assign flags.full      = (count_q == DEPTH_C);
	assign flags.empty     = (count_q == '0);
	assign flags.hit       = hit_q;
	assign flags.scan_busy = !match && ((scan_left_q != '0) || cmp_vld_q);

	assign res_status  = status_q;
	assign res_served  = served_q;
	assign res_pending = count_q;

endmodule

FILE: sv/dedup_work_queue_core.sv
// Top level of the duplicate-suppressing work queue: sequencer, datapath and result register.
//
// Item channel (item_valid/item_ready) takes an operation and a relation_id; a push
// enqueues the identifier unless the queue is full or already holds it, a pop returns
// the head entry. Result channel (result_valid/result_ready) gives one beat per item:
// status, served_id (zero unless dequeued) and the pending count after the operation.
// Items are handled one at a time by a microcoded sequencer over a single-port-read store.
// A pop or a push on a full queue goes straight to its result; any other push first runs the
// scan loop over the pending entries, comparing one stored entry per cycle (a duplicate ends
// the scan early). The next item can be taken in the cycle after the result is loaded.
// The result sits in an output register, so the next item is taken while a result still
// waits; if result_ready stays low, the following result waits at the emit step and
// item_ready stays low until the register is free.
// Reset empties the queue (head and count to zero); store contents are not cleared and
// need no clearing pass, as only written entries are ever read.
module dedup_work_queue_core import dwq_pkg::*; #(
	parameter int QUEUE_DEPTH = 256,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              operation,
	input  logic [ID_W-1:0]   relation_id,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   served_id,
	output logic [CNT_W-1:0]  pending
);

	ctrl_word_t        ctrl;
	dp_flags_t         flags;
	logic              accept;
	logic              out_busy;
	logic              load_out;
	logic [STAT_W-1:0] res_status;
	logic [ID_W-1:0]   res_served;
	logic [CNT_W-1:0]  res_pending;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   served_id_q;
	logic [CNT_W-1:0]  pending_q;

	assign item_ready = ctrl.in_rdy;
	assign accept     = item_valid && ctrl.in_rdy;
	assign out_busy   = out_valid_q && !result_ready;
	assign load_out   = (ctrl.act == ACT_EMIT) && !out_busy;

	dwq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_busy (out_busy),
		.flags    (flags),
		.ctrl     (ctrl)
	);

	dwq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (operation),
		.relation_id (relation_id),
		.act         (ctrl.act),
		.flags       (flags),
		.res_status  (res_status),
		.res_served  (res_served),
		.res_pending (res_pending)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q    <= res_status;
			served_id_q <= res_served;
			pending_q   <= res_pending;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign served_id    = served_id_q;
	assign pending      = pending_q;

endmodule
